// File: sv/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants of the fragment run allocator: controller
// commands, datapath status, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package fra_pkg;

	// fixed field widths
	localparam int FPB_W   = 4;
	localparam int MSZ_W   = 17;
	localparam int CNT_W   = 4;
	localparam int ADDR_W  = 16;
	localparam int TOTAL_W = 32;
	localparam int CFG_W   = 17;

	// largest block; also the width of one usage map word
	localparam int MAX_FPB = 8;
	localparam int WORD_W  = MAX_FPB;
	localparam int OFS_W   = 3;

	// configuration register indexes
	localparam logic CFG_FPB      = 1'b0;
	localparam logic CFG_MAP_SIZE = 1'b1;

	// item kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_MARK  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_step;      // write zero at sweep address, advance
		logic load;          // capture item, rewind group pointer
		logic rd_mark;       // read word holding the mark bit
		logic wr_mark;       // write back word with mark bit set
		logic rd_grp;        // read both words under current group
		logic next_grp;      // step to next group
		logic commit;        // write low word, note start and total
		logic wr_hi;         // write high word if the run spills into it
		logic emit_ok_alloc;
		logic emit_ok_mark;
		logic emit_fail;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_mark;
		logic mark_in_range;
		logic want_bad;
		logic grp_end;
		logic fit;
	} sts_t;

endpackage

// File: sv/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer of the allocator: clearing sweep, item dispatch, group scan.
// ----------------------------------------------------------------------------
module fra_ctrl import fra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_DISP    = 3'd2;
	localparam logic [2:0] ST_MARK_WR = 3'd3;
	localparam logic [2:0] ST_SCAN    = 3'd4;
	localparam logic [2:0] ST_CHECK   = 3'd5;
	localparam logic [2:0] ST_FIN     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				priority if (sts.is_mark && sts.mark_in_range) begin
					cmd.rd_mark = 1'b1;
					state_d     = ST_MARK_WR;
				end else if (sts.is_mark || sts.want_bad) begin
					cmd.emit_fail = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_MARK_WR: begin
				cmd.wr_mark      = 1'b1;
				cmd.emit_ok_mark = 1'b1;
				state_d          = ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.grp_end) begin
					cmd.emit_fail = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_grp = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.fit) begin
					cmd.commit = 1'b1;
					state_d    = ST_FIN;
				end else begin
					cmd.next_grp = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_FIN: begin
				cmd.wr_hi         = 1'b1;
				cmd.emit_ok_alloc = 1'b1;
				state_d           = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// one result per item, and the block is free right after it
	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_ok_alloc, cmd.emit_ok_mark, cmd.emit_fail}))
		else $error("more than one result issued at once");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ok_alloc || cmd.emit_ok_mark || cmd.emit_fail) |=> !busy)
		else $error("block still busy after result");

	// single write port on the map
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.wr_mark, cmd.commit, cmd.wr_hi}))
		else $error("two map writes in one cycle");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DISP))
		else $error("accepted item not dispatched");

endmodule

// File: sv/fra_dpath.sv
// ----------------------------------------------------------------------------
// fra_dpath
// Usage map memory, group pointer, run finder, running total and result
// registers.
// ----------------------------------------------------------------------------
module fra_dpath import fra_pkg::*; #(
	parameter int MAP_FRAGS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               kind,
	input  logic [CNT_W-1:0]   frag_count,
	input  logic [ADDR_W-1:0]  frag_address,
	output logic               done,
	output logic               ok,
	output logic [ADDR_W-1:0]  start_address,
	output logic [TOTAL_W-1:0] allocated_total
);

	localparam int DEPTH = (MAP_FRAGS + WORD_W - 1) / WORD_W;
	localparam int WAW   = $clog2(DEPTH);
	localparam int GW    = $clog2(MAP_FRAGS) + 1;
	localparam int CW    = ((GW > MSZ_W) ? GW : MSZ_W) + 1;

	logic [WORD_W-1:0] mem [DEPTH];

	logic [FPB_W-1:0]   fpb_q;
	logic [MSZ_W-1:0]   msz_q;
	logic               kind_q;
	logic [CNT_W-1:0]   want_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [GW-1:0]      grp_q;
	logic [WAW-1:0]     clr_q;
	logic [WORD_W-1:0]  rd_lo_q;
	logic [WORD_W-1:0]  rd_hi_q;
	logic [WORD_W-1:0]  new_hi_q;
	logic               hi_need_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  start_q;
	logic               done_q;
	logic               ok_q;

	logic [FPB_W-1:0]    fpb_eff;
	logic [CW-1:0]       lim_eff;
	logic [CW-1:0]       addr_x;
	logic [WAW-1:0]      w_idx;
	logic [WAW-1:0]      hi_idx;
	logic [WAW-1:0]      mark_idx;
	logic [OFS_W-1:0]    ofs;
	logic [WORD_W-1:0]   want_mask;
	logic [WORD_W-1:0]   fpb_mask;
	logic [2*WORD_W-1:0] win16;
	logic [2*WORD_W-1:0] used16;
	logic [2*WORD_W-1:0] set16;
	logic [OFS_W-1:0]    pos;
	logic                fit;
	logic [CW-1:0]       start_x;
	logic                we;
	logic [WAW-1:0]      wa;
	logic [WORD_W-1:0]   wd;
	logic [WAW-1:0]      ra;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpb_q <= FPB_W'(MAX_FPB);
			msz_q <= MSZ_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FPB:      fpb_q <= cfg_data[FPB_W-1:0];
				CFG_MAP_SIZE: msz_q <= cfg_data[MSZ_W-1:0];
				default:      ;
			endcase
		end
	end

	// clamped settings
	assign fpb_eff = (fpb_q > FPB_W'(MAX_FPB)) ? FPB_W'(MAX_FPB) : fpb_q;
	assign lim_eff = (CW'(msz_q) > CW'(MAP_FRAGS)) ? CW'(MAP_FRAGS) : CW'(msz_q);

	assign addr_x   = CW'(addr_q);
	assign mark_idx = addr_x[OFS_W +: WAW];
	assign w_idx    = grp_q[OFS_W +: WAW];
	assign hi_idx   = (w_idx == WAW'(DEPTH - 1)) ? '0 : w_idx + WAW'(1);
	assign ofs      = grp_q[OFS_W-1:0];

	assign want_mask = WORD_W'((9'd1 << want_q) - 9'd1);
	assign fpb_mask  = WORD_W'((9'd1 << fpb_eff) - 9'd1);

	// window of the group, bits past the block read as used
	assign win16  = {rd_hi_q, rd_lo_q} >> ofs;
	assign used16 = {{WORD_W{1'b1}}, win16[WORD_W-1:0] | ~fpb_mask};

	// first fitting start inside the group
	always_comb begin
		fit = 1'b0;
		pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if ((used16[j +: WORD_W] & want_mask) == '0) begin
				fit = 1'b1;
				pos = OFS_W'(j);
			end
		end
	end

	assign set16   = (2*WORD_W)'(want_mask) << ({1'b0, ofs} + {1'b0, pos});
	assign start_x = CW'(grp_q) + CW'(pos);

	// item capture, group pointer, sweep counter, running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			grp_q     <= '0;
			kind_q    <= 1'b0;
			want_q    <= '0;
			addr_q    <= '0;
			total_q   <= '0;
			hi_need_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + WAW'(1);
			end
			if (cmd.load) begin
				kind_q <= kind;
				want_q <= frag_count;
				addr_q <= frag_address;
				grp_q  <= '0;
			end else if (cmd.next_grp) begin
				grp_q <= grp_q + GW'(fpb_eff);
			end
			if (cmd.commit) begin
				total_q   <= total_q + TOTAL_W'(want_q);
				hi_need_q <= |set16[2*WORD_W-1:WORD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			new_hi_q <= rd_hi_q | set16[2*WORD_W-1:WORD_W];
		end
	end

	// single write port
	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		priority if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.wr_mark) begin
			we = 1'b1;
			wa = mark_idx;
			wd = rd_lo_q | (WORD_W'(1) << addr_q[OFS_W-1:0]);
		end else if (cmd.commit) begin
			we = 1'b1;
			wa = w_idx;
			wd = rd_lo_q | set16[WORD_W-1:0];
		end else if (cmd.wr_hi && hi_need_q) begin
			we = 1'b1;
			wa = hi_idx;
			wd = new_hi_q;
		end else begin
			we = 1'b0;
		end
	end

	assign ra = cmd.rd_mark ? mark_idx : w_idx;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_mark || cmd.rd_grp) begin
			rd_lo_q <= mem[ra];
			rd_hi_q <= mem[hi_idx];
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			start_q <= '0;
		end else begin
			done_q <= cmd.emit_ok_alloc | cmd.emit_ok_mark | cmd.emit_fail;
			ok_q   <= cmd.emit_ok_alloc | cmd.emit_ok_mark;
			if (cmd.commit) begin
				start_q <= start_x[ADDR_W-1:0];
			end else if (cmd.emit_fail || cmd.emit_ok_mark) begin
				start_q <= '0;
			end
		end
	end

	assign sts.clr_last      = (clr_q == WAW'(DEPTH - 1));
	assign sts.is_mark       = (kind_q == KIND_MARK);
	assign sts.mark_in_range = (addr_x < CW'(MAP_FRAGS));
	assign sts.want_bad      = (want_q == '0) || (want_q > fpb_eff);
	assign sts.grp_end       = (CW'(grp_q) + CW'(fpb_eff)) >= lim_eff;
	assign sts.fit           = fit;

	assign done            = done_q;
	assign ok              = ok_q;
	assign start_address   = start_q;
	assign allocated_total = total_q;

endmodule

// File: sv/fragment_run_allocator_unit.sv
// ----------------------------------------------------------------------------
// fragment_run_allocator_unit
// First-fit allocator of fragment runs over a one-bit-per-fragment usage map.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   ---------                  -------
//  item in   start, busy (start&!busy)  kind, frag_count, frag_address
//  result    done (one-cycle strobe)    ok, start_address, allocated_total
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
//  Steps: a mark is dispatched, then its word is read and written back with
//  the mark bit set as the result issues; a mark out of range or an allocate
//  with a bad count fails at dispatch; any other allocate does one map read
//  and one fit check per group examined, and fails once no group is left.
//  Reset: a clearing sweep zeroes the map, one 8-fragment word a cycle;
//  busy stays high meanwhile.
//  Stalls: none on the result side, the strobe is not held off. Config is
//  always ready and may only be written while the block is idle.
//
module fragment_run_allocator_unit import fra_pkg::*; #(
	parameter int MAP_FRAGS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	// item in
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [CNT_W-1:0]   frag_count,
	input  logic [ADDR_W-1:0]  frag_address,
	// result
	output logic               done,
	output logic               ok,
	output logic [ADDR_W-1:0]  start_address,
	output logic [TOTAL_W-1:0] allocated_total,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// registers are plain flops, a write lands in the next cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// sequencer: sweep, dispatch, group-by-group scan
	fra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// map memory, run finder, total and result registers
	fra_dpath #(
		.MAP_FRAGS (MAP_FRAGS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.frag_count      (frag_count),
		.frag_address    (frag_address),
		.done            (done),
		.ok              (ok),
		.start_address   (start_address),
		.allocated_total (allocated_total)
	);

endmodule
